FILE: sv/sbm_pkg.sv
// shared types for the sliding window bitrate meter
package sbm_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_EXP_RD,
    ST_EXP_WR,
    ST_ACT,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DIV,
    ST_QOUT
  } sbm_state_e;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam int unsigned NUM_W    = 53;
  localparam int unsigned WIN_W    = 11;
  localparam int unsigned WIN_RST  = 1000;

  typedef struct packed {
    logic in_ready;
    logic clr_step;
    logic load;
    logic exp_init;
    logic exp_step;
    logic exp_fin;
    logic first;
    logic upd_rd;
    logic upd_wr;
    logic q_prep;
    logic div_step;
    logic out_load;
  } sbm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic drop;
    logic exp_need;
    logic exp_more;
    logic q_zero;
    logic div_done;
    logic out_free;
  } sbm_status_t;

endpackage

FILE: sv/sbm_ram.sv
// generic single write, single read ram with registered read data
module sbm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/sbm_ctrl.sv
// controller state machine of the bitrate meter
module sbm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sbm_pkg::sbm_status_t status_i,
  output sbm_pkg::sbm_cmd_t    cmd_o
);
  import sbm_pkg::*;

  sbm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (status_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.drop) state_d = ST_IDLE;
        else if (status_i.exp_need) state_d = ST_EXP_RD;
        else state_d = ST_ACT;
      end
      ST_EXP_RD: state_d = status_i.exp_more ? ST_EXP_WR : ST_ACT;
      ST_EXP_WR: state_d = ST_EXP_RD;
      ST_ACT:    state_d = status_i.is_query ? ST_DIV : ST_UPD_RD;
      ST_UPD_RD: state_d = ST_UPD_WR;
      ST_UPD_WR: state_d = ST_IDLE;
      ST_DIV:    if (status_i.q_zero || status_i.div_done) state_d = ST_QOUT;
      ST_QOUT:   if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = in_valid_i;
      end
      ST_CHECK:  cmd_o.exp_init = !status_i.drop && status_i.exp_need;
      ST_EXP_RD: cmd_o.exp_fin = !status_i.exp_more;
      ST_EXP_WR: cmd_o.exp_step = 1'b1;
      ST_ACT: begin
        cmd_o.first  = !status_i.is_query;
        cmd_o.q_prep = status_i.is_query;
      end
      ST_UPD_RD: cmd_o.upd_rd = 1'b1;
      ST_UPD_WR: cmd_o.upd_wr = 1'b1;
      ST_DIV:    cmd_o.div_step = !status_i.q_zero;
      ST_QOUT:   cmd_o.out_load = status_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

FILE: sv/sbm_dp.sv
// datapath of the bitrate meter: totals, bucket ring, divider, output register
module sbm_dp #(
  parameter int unsigned MAX_WINDOW_MS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sbm_pkg::sbm_cmd_t                  cmd_i,
  output sbm_pkg::sbm_status_t               status_o,
  input  logic                               cfg_we_i,
  input  logic [sbm_pkg::WIN_W-1:0]          cfg_wdata_i,
  input  logic                               in_kind_i,
  input  logic [47:0]                        in_now_i,
  input  logic [15:0]                        in_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        out_rate_o,
  output logic                               out_avail_o
);
  import sbm_pkg::*;

  localparam int unsigned SW = $clog2(MAX_WINDOW_MS);
  localparam logic [SW:0] MAX_SL = (SW+1)'(MAX_WINDOW_MS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_WINDOW_MS - 1);
  localparam logic [WIN_W-1:0] WIN_INIT =
    WIN_W'((WIN_RST <= MAX_WINDOW_MS) ? WIN_RST : MAX_WINDOW_MS);
  localparam int unsigned DCW = $clog2(NUM_W);

  logic [WIN_W-1:0] window_q;
  logic             started_q;
  logic [47:0]      oldest_q;
  logic [SW-1:0]    slot_q;
  logic [39:0]      tbytes_q;
  logic [31:0]      tsamp_q;
  logic             kind_q;
  logic [47:0]      now_q;
  logic [15:0]      count_q;
  logic             gt_q;
  logic [47:0]      newold_q;
  logic [SW:0]      steps_q;
  logic [SW-1:0]    clr_q;
  logic [SW-1:0]    uslot_q;
  logic [NUM_W-1:0] num_q, quo_q;
  logic [WIN_W-1:0] den_q, rem_q;
  logic [DCW-1:0]   dcnt_q;
  logic             qzero_q;
  logic             out_valid_q, out_avail_q;
  logic [31:0]      out_rate_q;

  logic             ram_we;
  logic [SW-1:0]    ram_waddr, ram_raddr;
  logic [47:0]      ram_wdata, ram_rdata;

  sbm_ram #(.WIDTH(48), .DEPTH(MAX_WINDOW_MS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // bucket slot of the current timestamp, offset is below the ring size
  logic [47:0] off;
  logic [SW:0] slot_sum;
  logic [SW-1:0] upd_slot;
  assign off      = now_q - oldest_q;
  assign slot_sum = {1'b0, slot_q} + {1'b0, off[SW-1:0]};
  assign upd_slot = (slot_sum >= MAX_SL) ? SW'(slot_sum - MAX_SL) : slot_sum[SW-1:0];

  // update arithmetic
  logic [31:0] b_sum, room, add;
  logic [15:0] b_cnt;
  logic        b_full;
  logic [40:0] tb_sum;
  assign b_sum  = ram_rdata[31:0];
  assign b_cnt  = ram_rdata[47:32];
  assign room   = ~b_sum;
  assign add    = ({16'd0, count_q} <= room) ? {16'd0, count_q} : room;
  assign b_full = (b_cnt == 16'hFFFF);
  assign tb_sum = {1'b0, tbytes_q} + {9'd0, add};

  // query preparation
  logic [48:0] active;
  logic        q_zero;
  logic [NUM_W-1:0] scaled;
  assign active = {1'b0, now_q} - {1'b0, oldest_q} + 49'd1;
  assign q_zero = !started_q || (tsamp_q == 32'd0) || (now_q < oldest_q) ||
                  (active <= 49'd1) ||
                  ((tsamp_q <= 32'd1) && (active < {38'd0, window_q}));
  // x * 8000 = x * 8192 - x * 128 - x * 64
  assign scaled = ({tbytes_q, 13'd0} - {6'd0, tbytes_q, 7'd0} - {7'd0, tbytes_q, 6'd0})
                  + NUM_W'(active[WIN_W-1:1]);

  // one restoring divide step per cycle
  logic [WIN_W:0] div_sh;
  logic           div_ge;
  assign div_sh = {rem_q, num_q[NUM_W-1]};
  assign div_ge = div_sh >= {1'b0, den_q};

  logic [48:0] now_p1;
  assign now_p1 = {1'b0, in_now_i} + 49'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
    end else if (cmd_i.exp_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.upd_wr) begin
      ram_we    = 1'b1;
      ram_waddr = uslot_q;
      ram_wdata = {b_full ? b_cnt : b_cnt + 16'd1, b_sum + add};
    end
    ram_raddr = cmd_i.upd_rd ? upd_slot : slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WIN_INIT;
      started_q   <= 1'b0;
      oldest_q    <= '0;
      slot_q      <= '0;
      tbytes_q    <= '0;
      tsamp_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_wdata_i != '0) &&
          ({21'd0, cfg_wdata_i} <= 32'(MAX_WINDOW_MS))) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.exp_step) begin
        tbytes_q <= (tbytes_q >= {8'd0, b_sum}) ? tbytes_q - {8'd0, b_sum} : '0;
        tsamp_q  <= (tsamp_q >= {16'd0, b_cnt}) ? tsamp_q - {16'd0, b_cnt} : '0;
        slot_q   <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
        oldest_q <= oldest_q + 48'd1;
      end
      if (cmd_i.exp_fin) oldest_q <= newold_q;
      if (cmd_i.first && !started_q) begin
        oldest_q  <= now_q;
        started_q <= 1'b1;
      end
      if (cmd_i.upd_wr) begin
        tbytes_q <= tb_sum[40] ? '1 : tb_sum[39:0];
        if (!b_full && (tsamp_q != 32'hFFFF_FFFF)) tsamp_q <= tsamp_q + 32'd1;
      end
      // output register frees on a transfer, refills from a finished query
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= in_kind_i;
      now_q    <= in_now_i;
      count_q  <= in_count_i;
      gt_q     <= now_p1 > {38'd0, window_q};
      newold_q <= 48'(now_p1 - {38'd0, window_q});
    end
    if (cmd_i.exp_init) steps_q <= '0;
    if (cmd_i.exp_step) steps_q <= steps_q + 1'b1;
    if (cmd_i.upd_rd) uslot_q <= upd_slot;
    if (cmd_i.q_prep) begin
      qzero_q <= q_zero;
      num_q   <= scaled;
      den_q   <= active[WIN_W-1:0];
      rem_q   <= '0;
      quo_q   <= '0;
      dcnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= div_ge ? WIN_W'(div_sh - {1'b0, den_q}) : div_sh[WIN_W-1:0];
      quo_q  <= {quo_q[NUM_W-2:0], div_ge};
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_avail_q <= !qzero_q;
      if (qzero_q) out_rate_q <= '0;
      else if (quo_q[NUM_W-1:32] != '0) out_rate_q <= '1;
      else out_rate_q <= quo_q[31:0];
    end
  end

  assign status_o.clr_done = (clr_q == LAST_SLOT);
  assign status_o.is_query = (kind_q == KIND_QUERY);
  assign status_o.drop     = (kind_q == KIND_UPDATE) && started_q && (now_q < oldest_q);
  assign status_o.exp_need = started_q && gt_q && (newold_q > oldest_q);
  assign status_o.exp_more = (tsamp_q != '0) && (oldest_q < newold_q) && (steps_q != MAX_SL);
  assign status_o.q_zero   = qzero_q;
  assign status_o.div_done = (dcnt_q == DCW'(NUM_W - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rate_o  = out_rate_q;
  assign out_avail_o = out_avail_q;

endmodule

FILE: sv/sliding_window_bitrate_meter_unit.sv
// top level of the sliding window bitrate meter
//
// input stream: tuser is the kind (0 adds a byte count, 1 asks for the rate),
// tdata carries the timestamp in ms and the byte count. updates give no output,
// every query gives exactly one output transfer with the rate in bits per
// second (tdata) and the rate-available flag (tuser).
// the window length is written through cfg_we_i / cfg_wdata_i; the user writes it
// only while idle, which the block itself does not enforce. values of zero or above
// the bucket count are ignored. one item is in work at a time. after its
// transfer an update is checked, expires old buckets when expiry runs (a read and
// a write per expired bucket), then reads its bucket and writes it back; a stale
// update is dropped after the check. a query is checked, expires buckets in the
// same way, then runs the bit-serial divider (no divide steps when the answer is
// zero), then loads the output register once that register is free.
// after reset the bucket ram is cleared, one bucket per cycle; tready stays low
// during that pass.
// a result waits in the output register while the receiver stalls; new items
// are taken meanwhile, and a further query holds until that register frees.
module sliding_window_bitrate_meter_unit #(
  parameter int unsigned MAX_WINDOW_MS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sbm_pkg::WIN_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // now_ms[47:0], count[63:48]
  input  logic                      s_axis_tuser,  // kind
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // rate
  output logic                      m_axis_tuser   // rate_available
);
  import sbm_pkg::*;

  sbm_cmd_t    cmd;
  sbm_status_t status;

  sbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbm_dp #(.MAX_WINDOW_MS(MAX_WINDOW_MS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser),
    .in_now_i    (s_axis_tdata[47:0]),
    .in_count_i  (s_axis_tdata[63:48]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rate_o  (m_axis_tdata),
    .out_avail_o (m_axis_tuser)
  );

  assign s_axis_tready = cmd.in_ready;

`ifndef ASSERT_OFF
  a_zero_when_unavail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("rate not zero without rate_available");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");
`endif

endmodule

FILE: test/tb_top.sv
// testbench for the sliding window bitrate meter: directed and random streams checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import sbm_pkg::*;

  localparam int unsigned BUCKETS = 1024;
  localparam int unsigned WDOG_LIMIT = 40000;

  typedef struct packed {
    logic        kind;
    logic [47:0] now_ms;
    logic [15:0] count;
  } meter_item_t;

  typedef struct packed {
    logic [31:0] rate;
    logic        avail;
  } rate_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [WIN_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;

  sliding_window_bitrate_meter_unit #(.MAX_WINDOW_MS(BUCKETS)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] p_sum [BUCKETS];
  logic [15:0] p_cnt [BUCKETS];
  logic [39:0] p_bytes;
  logic [31:0] p_samples;
  logic [47:0] p_oldest;
  logic [9:0]  p_slot;
  logic        p_started;
  logic [10:0] p_window;

  meter_item_t pending_items[$];
  rate_res_t   expected_rates[$];
  bit          hold_sender;
  int          errors;
  int          idle_cycles;
  int          burst_left, gap_left;

  function automatic void meter_reset();
    for (int i = 0; i < BUCKETS; i++) begin
      p_sum[i] = '0;
      p_cnt[i] = '0;
    end
    p_bytes = '0;
    p_samples = '0;
    p_oldest = '0;
    p_slot = '0;
    p_started = 1'b0;
    p_window = 11'(WIN_RST);
  endfunction

  function automatic void meter_config(logic [10:0] v);
    if (v != 0 && v <= BUCKETS) p_window = v;
  endfunction

  function automatic void expire_buckets(logic [47:0] now);
    logic [48:0] new_oldest;
    int steps;
    steps = 0;
    if (!p_started) return;
    if ({1'b0, now} + 49'd1 <= p_window) return;
    new_oldest = {1'b0, now} + 49'd1 - p_window;
    if (new_oldest <= p_oldest) return;
    while (p_samples > 0 && p_oldest < new_oldest && steps < BUCKETS) begin
      p_bytes = (p_bytes >= p_sum[p_slot]) ? p_bytes - p_sum[p_slot] : '0;
      p_samples = (p_samples >= p_cnt[p_slot]) ? p_samples - p_cnt[p_slot] : '0;
      p_sum[p_slot] = '0;
      p_cnt[p_slot] = '0;
      p_slot++;
      p_oldest++;
      steps++;
    end
    p_oldest = new_oldest[47:0];
  endfunction

  // applies one item; returns 1 and fills r for a query
  function automatic bit meter_step(meter_item_t it, output rate_res_t r);
    logic [47:0] offset;
    logic [9:0]  s;
    logic [32:0] room;
    logic [31:0] add;
    logic [40:0] tb;
    logic [48:0] active;
    logic [63:0] q;
    r = '0;
    if (it.kind == KIND_UPDATE) begin
      if (p_started && it.now_ms < p_oldest) return 0;
      expire_buckets(it.now_ms);
      if (!p_started) begin
        p_oldest = it.now_ms;
        p_started = 1'b1;
      end
      offset = it.now_ms - p_oldest;
      s = p_slot + offset[9:0];
      room = 33'hFFFFFFFF - p_sum[s];
      add = (it.count <= room) ? 32'(it.count) : room[31:0];
      p_sum[s] += add;
      tb = p_bytes + add;
      p_bytes = tb[40] ? '1 : tb[39:0];
      if (p_cnt[s] != 16'hFFFF) begin
        p_cnt[s]++;
        if (p_samples != 32'hFFFFFFFF) p_samples++;
      end
      return 0;
    end
    expire_buckets(it.now_ms);
    if (!p_started || p_samples == 0 || it.now_ms < p_oldest) return 1;
    active = {1'b0, it.now_ms - p_oldest} + 49'd1;
    if (active <= 1) return 1;
    if (p_samples <= 1 && active < p_window) return 1;
    q = (64'(p_bytes) * 64'd8000 + 64'(active) / 2) / 64'(active);
    r.rate = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    r.avail = 1'b1;
    return 1;
  endfunction

  // driver: bursts and gaps
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      meter_item_t it;
      rate_res_t r;
      it = pending_items.pop_front();
      if (meter_step(it, r)) expected_rates.push_back(r);
    end
    if (s_axis_tvalid && !s_axis_tready) begin
      // hold the current transfer
    end else if (pending_items.size() > 0 && !hold_sender && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_items[0].kind;
        s_axis_tdata <= {pending_items[0].count, pending_items[0].now_ms};
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end else s_axis_tvalid <= 1'b0;
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      rate_res_t exp_r;
      if (expected_rates.size() == 0) begin
        $error("unexpected result rate=%0d avail=%0b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        exp_r = expected_rates.pop_front();
        if (m_axis_tdata !== exp_r.rate) begin
          $error("rate: expected %0d, got %0d", exp_r.rate, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== exp_r.avail) begin
          $error("rate_available: expected %0b, got %0b", exp_r.avail, m_axis_tuser);
          errors++;
        end
      end
    end
    m_axis_tready <= ($time / 640) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  logic [47:0] clock_ms;

  function automatic void add_item(logic kind, logic [47:0] now, logic [15:0] cnt);
    meter_item_t it;
    it.kind = kind;
    it.now_ms = now;
    it.count = cnt;
    pending_items.push_back(it);
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_rates.size() > 0)
      @(posedge clk_i);
    // a trailing update may still be expiring buckets
    repeat (2 * BUCKETS + 80) @(posedge clk_i);
  endtask

  task automatic write_window(logic [10:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    meter_config(v);
  endtask

  // random phase: mostly monotonic time, a few stale or far jumps
  task automatic random_phase(int n, int max_step);
    for (int i = 0; i < n; i++) begin
      int sel;
      logic [15:0] cnt;
      sel = $urandom_range(0, 99);
      if (sel < 3) clock_ms = clock_ms + $urandom_range(1000, 5000);
      else if (sel < 70) clock_ms = clock_ms + $urandom_range(0, max_step);
      cnt = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
      if (sel >= 95) add_item(KIND_UPDATE, clock_ms - $urandom_range(0, 2000), cnt);
      else add_item($urandom_range(0, 2) == 0 ? KIND_QUERY : KIND_UPDATE, clock_ms, cnt);
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_sender = 1'b0;
    burst_left = 0;
    gap_left = 0;
    meter_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty query, first sample, single sample, extremes
    add_item(KIND_QUERY, 48'd5, 16'd0);
    add_item(KIND_UPDATE, 48'd100, 16'd0);
    add_item(KIND_QUERY, 48'd100, 16'd0);
    add_item(KIND_QUERY, 48'd200, 16'd0);
    add_item(KIND_UPDATE, 48'd101, 16'hFFFF);
    add_item(KIND_QUERY, 48'd101, 16'hFFFF);
    add_item(KIND_QUERY, 48'd99, 16'd0);
    add_item(KIND_UPDATE, 48'd50, 16'd7);
    add_item(KIND_QUERY, 48'd1099, 16'd0);
    add_item(KIND_QUERY, 48'd1100, 16'd0);
    add_item(KIND_UPDATE, 48'd5000, 16'd1);
    add_item(KIND_QUERY, 48'd9000, 16'd0);
    drain();
    write_window(11'd1);
    add_item(KIND_UPDATE, 48'hFFFF_FFFF_FFF0, 16'hFFFF);
    add_item(KIND_QUERY, 48'hFFFF_FFFF_FFF0, 16'd0);
    add_item(KIND_QUERY, 48'hFFFF_FFFF_FFFF, 16'd0);
    drain();
    write_window(11'd0);
    write_window(11'd2047);
    write_window(11'd1025);
    write_window(11'd2);
    clock_ms = 48'hFFFF_FFFF_FFF8;
    add_item(KIND_UPDATE, clock_ms, 16'h5555);
    add_item(KIND_UPDATE, clock_ms + 1, 16'hAAAA);
    add_item(KIND_QUERY, clock_ms + 1, 16'd0);
    drain();

    // random phases over several windows, the extremes among them
    write_window(11'd1024);
    clock_ms = 48'h8000_0000_0000 | 48'($urandom);
    random_phase(250, 3);
    // pause the sender midway until every expected result has come
    while (pending_items.size() > 125) @(posedge clk_i);
    hold_sender = 1'b1;
    @(posedge clk_i);
    while (s_axis_tvalid || expected_rates.size() > 0) @(posedge clk_i);
    hold_sender = 1'b0;
    drain();
    write_window(11'd1);
    random_phase(150, 2);
    drain();
    write_window(11'(1 + $urandom_range(1, 60)));
    random_phase(250, 4);
    drain();
    write_window(11'd1024);
    // dense saturating burst into few buckets
    for (int i = 0; i < 150; i++)
      add_item((i % 10 == 9) ? KIND_QUERY : KIND_UPDATE, clock_ms + i / 40, 16'hFFFF);
    clock_ms += 4;
    random_phase(230, 1);
    drain();

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
